// File: hw/rtl/assert_macros.svh
// Assertion macros used by the port-level checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is low
`define ASSERT_CLK(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked implication, disabled while reset is low
`define ASSERT_IMPL(name, clk, rst_n, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

`endif

// File: hw/rtl/u8u16_pkg.sv
// Shared types and constants of the UTF-8 to UTF-16 transcoder
`default_nettype none

package u8u16_pkg;

  localparam int unsigned QueueDepthDefault = 4;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned UnitW  = 16;
  localparam int unsigned PointW = 21;
  localparam int unsigned PairW  = 20;

  localparam logic [7:0] LeadTwo   = 8'hC0;
  localparam logic [7:0] LeadThree = 8'hE0;
  localparam logic [7:0] LeadFour  = 8'hF0;
  localparam logic [7:0] LeadBad   = 8'hF8;

  localparam logic [PointW-1:0] MinTwo      = 21'h00080;
  localparam logic [PointW-1:0] MinThree    = 21'h00800;
  localparam logic [PointW-1:0] MinFour     = 21'h10000;
  localparam logic [PointW-1:0] SurrLo      = 21'h0D800;
  localparam logic [PointW-1:0] SurrHi      = 21'h0E000;
  localparam logic [PointW-1:0] PointLimit  = 21'h110000;

  localparam logic [UnitW-1:0] HighSurrBase = 16'hD800;
  localparam logic [UnitW-1:0] LowSurrBase  = 16'hDC00;

  localparam logic [1:0] SeqTwo   = 2'd1;
  localparam logic [1:0] SeqThree = 2'd2;
  localparam logic [1:0] SeqFour  = 2'd3;

  typedef enum logic [1:0] {
    KIND_UNIT,
    KIND_PAIR,
    KIND_ERROR
  } kind_e;

  typedef struct packed {
    kind_e            kind;
    logic [PairW-1:0] val;
  } entry_t;

endpackage

`default_nettype wire

// File: hw/rtl/utf8_to_utf16_transcoder.sv
// Path: a byte that completes a code point writes its result into the result queue, and
// the emitter then loads it into the output register, from which it transfers out.
// Throughput: one byte and one output unit per cycle while neither side stalls; a surrogate pair
// takes two output units, which its four input bytes cover, so only output stalls slow the input.
// The input stalls only while the result queue between decoder and emitter is full.
// Reset (rst_ni low, asynchronous): decoder idle, queue empty, no result pending.
`default_nettype none

module utf8_to_utf16_transcoder
  import u8u16_pkg::*;
#(
  parameter int unsigned QueueDepth = QueueDepthDefault
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic [ByteW-1:0] data_byte_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic [UnitW-1:0]      code_unit_o,
  output logic                  is_error_o,
  output logic                  is_last_o
);

  logic   accept;
  logic   push;
  entry_t entry;
  entry_t head;
  logic   pop;
  logic   empty;
  logic   full;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  u8u16_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .data_byte_i (data_byte_i),
    .push_o      (push),
    .entry_o     (entry)
  );

  u8u16_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .pop_i   (pop),
    .head_o  (head),
    .empty_o (empty),
    .full_o  (full)
  );

  u8u16_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .code_unit_o (code_unit_o),
    .is_error_o  (is_error_o),
    .is_last_o   (is_last_o)
  );

endmodule

`default_nettype wire

// File: hw/rtl/u8u16_front.sv
// Front decoder: accepts bytes, tracks the open sequence, classifies results
`default_nettype none

module u8u16_front
  import u8u16_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             accept_i,
  input  wire logic [ByteW-1:0] data_byte_i,
  output logic                  push_o,
  output entry_t                entry_o
);

  logic [PointW-1:0] point_q, point_d;
  logic [1:0]        due_q, due_d;
  logic [1:0]        len_q, len_d;
  logic [PointW-1:0] point_next;
  logic [PointW-1:0] min_val;
  logic [PointW-1:0] pair_val;

  assign point_next = {point_q[PointW-7:0], data_byte_i[5:0]};
  assign pair_val   = point_next - MinFour;

  always_comb begin
    unique case (len_q)
      SeqTwo:   min_val = MinTwo;
      SeqThree: min_val = MinThree;
      default:  min_val = MinFour;
    endcase
  end

  always_comb begin
    point_d = point_q;
    due_d   = due_q;
    len_d   = len_q;
    push_o  = 1'b0;
    entry_o = '{kind: KIND_UNIT, val: '0};
    if (accept_i) begin
      if (due_q == 2'd0) begin
        if (!data_byte_i[7]) begin
          push_o  = 1'b1;
          entry_o = '{kind: KIND_UNIT, val: PairW'(data_byte_i)};
        end else if (data_byte_i < LeadTwo || data_byte_i >= LeadBad) begin
          push_o  = 1'b1;
          entry_o = '{kind: KIND_ERROR, val: '0};
        end else if (data_byte_i < LeadThree) begin
          point_d = PointW'(data_byte_i[4:0]);
          len_d   = SeqTwo;
          due_d   = SeqTwo;
        end else if (data_byte_i < LeadFour) begin
          point_d = PointW'(data_byte_i[3:0]);
          len_d   = SeqThree;
          due_d   = SeqThree;
        end else begin
          point_d = PointW'(data_byte_i[2:0]);
          len_d   = SeqFour;
          due_d   = SeqFour;
        end
      end else if (data_byte_i[7:6] != 2'b10) begin
        point_d = '0;
        due_d   = 2'd0;
        len_d   = 2'd0;
        push_o  = 1'b1;
        entry_o = '{kind: KIND_ERROR, val: '0};
      end else if (due_q != 2'd1) begin
        point_d = point_next;
        due_d   = due_q - 2'd1;
      end else begin
        point_d = '0;
        due_d   = 2'd0;
        len_d   = 2'd0;
        push_o  = 1'b1;
        priority if (point_next < min_val || point_next >= PointLimit ||
                     (point_next >= SurrLo && point_next < SurrHi)) begin
          entry_o = '{kind: KIND_ERROR, val: '0};
        end else if (point_next < MinFour) begin
          entry_o = '{kind: KIND_UNIT, val: point_next[PairW-1:0]};
        end else begin
          entry_o = '{kind: KIND_PAIR, val: pair_val[PairW-1:0]};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      point_q <= '0;
      due_q   <= 2'd0;
      len_q   <= 2'd0;
    end else begin
      point_q <= point_d;
      due_q   <= due_d;
      len_q   <= len_d;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/u8u16_queue.sv
// Short queue of classified results between the decoder and the emitter
`default_nettype none

module u8u16_queue
  import u8u16_pkg::*;
#(
  parameter int unsigned Depth = QueueDepthDefault
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   push_i,
  input  wire entry_t entry_i,
  input  wire logic   pop_i,
  output entry_t      head_o,
  output logic        empty_o,
  output logic        full_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  entry_t          mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == CntW'(Depth));
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/u8u16_back.sv
// Back emitter: turns queued results into UTF-16 units in an output register
`default_nettype none

module u8u16_back
  import u8u16_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire entry_t           head_i,
  input  wire logic             empty_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic [UnitW-1:0]      code_unit_o,
  output logic                  is_error_o,
  output logic                  is_last_o
);

  logic             valid_q, valid_d;
  logic             half_q, half_d;
  logic [UnitW-1:0] unit_q, unit_d;
  logic             err_q, err_d;
  logic             last_q, last_d;
  logic             load;

  assign load = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    half_d  = half_q;
    unit_d  = unit_q;
    err_d   = err_q;
    last_d  = last_q;
    pop_o   = 1'b0;
    if (load) begin
      valid_d = !empty_i;
      if (!empty_i) begin
        unique case (head_i.kind)
          KIND_UNIT: begin
            unit_d = head_i.val[UnitW-1:0];
            err_d  = 1'b0;
            last_d = 1'b1;
            pop_o  = 1'b1;
          end
          KIND_PAIR: begin
            err_d = 1'b0;
            if (!half_q) begin
              unit_d = HighSurrBase + UnitW'(head_i.val[PairW-1:10]);
              last_d = 1'b0;
              half_d = 1'b1;
            end else begin
              unit_d = LowSurrBase + UnitW'(head_i.val[9:0]);
              last_d = 1'b1;
              half_d = 1'b0;
              pop_o  = 1'b1;
            end
          end
          default: begin
            unit_d = '0;
            err_d  = 1'b1;
            last_d = 1'b1;
            pop_o  = 1'b1;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      half_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      half_q  <= half_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unit_q <= unit_d;
    err_q  <= err_d;
    last_q <= last_d;
  end

  assign out_valid_o = valid_q;
  assign code_unit_o = unit_q;
  assign is_error_o  = err_q;
  assign is_last_o   = last_q;

endmodule

`default_nettype wire

// File: hw/rtl/u8u16_checker.sv
// Port-level checker for the transcoder, bound to the top level
`default_nettype none
`include "assert_macros.svh"

module u8u16_checker
  import u8u16_pkg::*;
(
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             in_valid_i,
  input wire logic             in_stall_o,
  input wire logic [ByteW-1:0] data_byte_i,
  input wire logic             out_valid_o,
  input wire logic             out_stall_i,
  input wire logic [UnitW-1:0] code_unit_o,
  input wire logic             is_error_o,
  input wire logic             is_last_o
);

  logic out_xfer;
  logic in_xfer;

  assign out_xfer = out_valid_o && !out_stall_i;
  assign in_xfer  = in_valid_i && !in_stall_o && (data_byte_i == data_byte_i);

  `ASSERT_CLK(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o, "stalled result dropped")
  `ASSERT_CLK(a_out_stable, clk_i, rst_ni, out_valid_o && out_stall_i |=> $stable(code_unit_o) && $stable(is_error_o) && $stable(is_last_o), "stalled result changed")
  `ASSERT_IMPL(a_err_form, clk_i, rst_ni, out_valid_o && is_error_o, code_unit_o == '0 && is_last_o, "error transfer not zero or not last")
  `ASSERT_IMPL(a_high_surr, clk_i, rst_ni, out_valid_o && !is_last_o, code_unit_o[15:10] == 6'b110110 && !is_error_o, "non-last transfer is not a high surrogate")
  `ASSERT_CLK(a_low_follows, clk_i, rst_ni, out_xfer && !is_last_o && !in_xfer |=> out_valid_o && is_last_o && code_unit_o[15:10] == 6'b110111, "high surrogate not followed by low surrogate")

endmodule

bind utf8_to_utf16_transcoder u8u16_checker u_u8u16_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .data_byte_i (data_byte_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .code_unit_o (code_unit_o),
  .is_error_o  (is_error_o),
  .is_last_o   (is_last_o)
);

`default_nettype wire

// File: verif/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench of the UTF-8 to UTF-16 transcoder
module testbench;
  import u8u16_pkg::*;

  typedef enum logic [1:0] {
    PH_STEADY,
    PH_SEND_GAPS,
    PH_RECV_STALLS,
    PH_BOTH
  } pace_e;

  typedef struct {
    logic [ByteW-1:0] value;
    pace_e            pace;
  } utf8_byte_t;

  typedef struct {
    logic [UnitW-1:0] code;
    logic             err;
    logic             last;
  } utf16_unit_t;

  localparam int unsigned ByteTarget = 1900;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [ByteW-1:0]   data_byte_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [UnitW-1:0]   code_unit_o;
  logic               is_error_o;
  logic               is_last_o;

  utf8_byte_t  utf8_bytes_q[$];
  utf16_unit_t awaited_units_q[$];
  utf16_unit_t head_unit;
  pace_e       fill_pace = PH_STEADY;
  pace_e       feed_pace = PH_STEADY;
  int          mismatches = 0;

  logic [PointW-1:0] point_acc = '0;
  logic [1:0]        bytes_left = '0;
  logic [1:0]        seq_len = '0;

  utf8_to_utf16_transcoder u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .data_byte_i (data_byte_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .code_unit_o (code_unit_o),
    .is_error_o  (is_error_o),
    .is_last_o   (is_last_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned idle_pct(input pace_e pace, input logic receiver);
    case (pace)
      PH_SEND_GAPS:   idle_pct = receiver ? 0 : 46;
      PH_RECV_STALLS: idle_pct = receiver ? 46 : 0;
      PH_BOTH:        idle_pct = 29;
      default:        idle_pct = 0;
    endcase
  endfunction

  task automatic push_byte(input logic [ByteW-1:0] value);
    utf8_byte_t item;
    item.value = value;
    item.pace = fill_pace;
    utf8_bytes_q.push_back(item);
  endtask

  // Encode a point in n bytes (overlong when small) and queue the first keep of them.
  task automatic emit_point(input logic [PointW-1:0] cp, input int n, input int keep);
    logic [ByteW-1:0] seq [4];
    seq[0] = '0;
    seq[1] = '0;
    seq[2] = '0;
    seq[3] = '0;
    case (n)
      1: seq[0] = {1'b0, cp[6:0]};
      2: begin
        seq[0] = {3'b110, cp[10:6]};
        seq[1] = {2'b10, cp[5:0]};
      end
      3: begin
        seq[0] = {4'b1110, cp[15:12]};
        seq[1] = {2'b10, cp[11:6]};
        seq[2] = {2'b10, cp[5:0]};
      end
      default: begin
        seq[0] = {5'b11110, cp[20:18]};
        seq[1] = {2'b10, cp[17:12]};
        seq[2] = {2'b10, cp[11:6]};
        seq[3] = {2'b10, cp[5:0]};
      end
    endcase
    for (int i = 0; i < keep; i++) push_byte(seq[i]);
  endtask

  task automatic add_random_sequence();
    int unsigned pick;
    int          n;
    logic [PointW-1:0] cp;
    pick = $urandom_range(0, 99);
    n = $urandom_range(1, 4);
    if (pick < 70) begin
      case (n)
        1: cp = PointW'($urandom_range(0, 'h7F));
        2: cp = PointW'($urandom_range('h80, 'h7FF));
        3: begin
          cp = PointW'($urandom_range('h800, 'hF7FF));
          if (cp >= SurrLo) cp = cp + 21'h800;
        end
        default: cp = PointW'($urandom_range('h10000, 'h10FFFF));
      endcase
      emit_point(cp, n, n);
    end else if (pick < 76) begin
      n = $urandom_range(2, 4);
      cp = PointW'($urandom_range(0, (n == 2) ? 'h7F : (n == 3) ? 'h7FF : 'hFFFF));
      emit_point(cp, n, n);
    end else if (pick < 80) begin
      emit_point(PointW'($urandom_range('hD800, 'hDFFF)), 3, 3);
    end else if (pick < 84) begin
      emit_point(PointW'($urandom_range('h110000, 'h1FFFFF)), 4, 4);
    end else if (pick < 92) begin
      n = $urandom_range(2, 4);
      emit_point(PointW'($urandom_range(0, 'h1FFFFF)), n, $urandom_range(1, n - 1));
      push_byte(ByteW'($urandom_range(0, 255)));
    end else begin
      push_byte(ByteW'($urandom_range(0, 255)));
    end
  endtask

  task automatic expect_unit(input logic [UnitW-1:0] code, input logic err, input logic last);
    utf16_unit_t unit;
    unit.code = code;
    unit.err = err;
    unit.last = last;
    awaited_units_q.push_back(unit);
  endtask

  task automatic reject_sequence();
    point_acc = '0;
    bytes_left = '0;
    seq_len = '0;
    expect_unit('0, 1'b1, 1'b1);
  endtask

  task automatic decode_byte(input logic [ByteW-1:0] b);
    logic [PointW-1:0] min_point;
    logic [PairW-1:0]  offset;
    if (bytes_left == 2'd0) begin
      if (b < 8'h80) begin
        expect_unit({8'h00, b}, 1'b0, 1'b1);
      end else if (b < LeadTwo || b >= LeadBad) begin
        reject_sequence();
      end else begin
        if (b < LeadThree) begin
          point_acc = {16'd0, b[4:0]};
          seq_len = SeqTwo;
        end else if (b < LeadFour) begin
          point_acc = {17'd0, b[3:0]};
          seq_len = SeqThree;
        end else begin
          point_acc = {18'd0, b[2:0]};
          seq_len = SeqFour;
        end
        bytes_left = seq_len;
      end
    end else if (b[7:6] != 2'b10) begin
      reject_sequence();
    end else begin
      point_acc = {point_acc[PointW-7:0], b[5:0]};
      bytes_left = bytes_left - 2'd1;
      if (bytes_left == 2'd0) begin
        min_point = (seq_len == SeqTwo) ? MinTwo : (seq_len == SeqThree) ? MinThree : MinFour;
        if (point_acc < min_point || (point_acc >= SurrLo && point_acc < SurrHi) ||
            point_acc >= PointLimit) begin
          reject_sequence();
        end else begin
          if (point_acc < MinFour) begin
            expect_unit(point_acc[UnitW-1:0], 1'b0, 1'b1);
          end else begin
            offset = point_acc[PairW-1:0] - 20'h10000;
            expect_unit(HighSurrBase + {6'd0, offset[19:10]}, 1'b0, 1'b0);
            expect_unit(LowSurrBase + {6'd0, offset[9:0]}, 1'b0, 1'b1);
          end
          point_acc = '0;
          seq_len = '0;
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      data_byte_i <= '0;
      feed_pace <= PH_STEADY;
    end else if (!in_valid_i || !in_stall_o) begin
      if (utf8_bytes_q.size() != 0 &&
          $urandom_range(0, 99) >= idle_pct(utf8_bytes_q[0].pace, 1'b0)) begin
        in_valid_i <= 1'b1;
        data_byte_i <= utf8_bytes_q[0].value;
        feed_pace <= utf8_bytes_q[0].pace;
        void'(utf8_bytes_q.pop_front());
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (awaited_units_q.size() == 0) begin
          $error("unexpected transfer: code_unit %h is_error %b is_last %b",
                 code_unit_o, is_error_o, is_last_o);
          mismatches++;
        end else begin
          head_unit = awaited_units_q.pop_front();
          if (code_unit_o !== head_unit.code) begin
            $error("code_unit: expected %h, actual %h", head_unit.code, code_unit_o);
            mismatches++;
          end
          if (is_error_o !== head_unit.err) begin
            $error("is_error: expected %b, actual %b", head_unit.err, is_error_o);
            mismatches++;
          end
          if (is_last_o !== head_unit.last) begin
            $error("is_last: expected %b, actual %b", head_unit.last, is_last_o);
            mismatches++;
          end
        end
      end
      if (in_valid_i && !in_stall_o) decode_byte(data_byte_i);
      out_stall_i <= ($urandom_range(0, 99) < idle_pct(feed_pace, 1'b1));
    end
  end

  initial begin
    push_byte(8'h00);
    push_byte(8'h7F);
    push_byte(8'h80);
    push_byte(8'hF8);
    push_byte(8'hFF);
    emit_point(21'h80, 2, 2);
    emit_point(21'h00, 2, 2);
    emit_point(21'hD800, 3, 3);
    emit_point(21'h10000, 4, 4);
    emit_point(21'h10FFFF, 4, 4);
    emit_point(21'h110000, 4, 4);
    push_byte(8'hC2);
    push_byte(8'h41);
    while (utf8_bytes_q.size() < ByteTarget) begin
      case (utf8_bytes_q.size() * 4 / ByteTarget)
        0: fill_pace = PH_STEADY;
        1: fill_pace = PH_SEND_GAPS;
        2: fill_pace = PH_RECV_STALLS;
        default: fill_pace = PH_BOTH;
      endcase
      add_random_sequence();
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (utf8_bytes_q.size() != 0 || in_valid_i) @(posedge clk_i);
    while (awaited_units_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
